// ----- sv/spa_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the slotted page allocator
// no dependencies
package spa_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_SLOTS_DEF  = 64;
  localparam int OFF_W          = 13;
  localparam int HDR_BYTES      = 12;
  localparam int SLOT_BYTES     = 8;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_BAD   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_BAD_SLOT  = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [12:0] obj_bytes;
    logic [5:0]  rel_slot;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  granted_slot;
    logic [12:0] object_offset;
    logic        did_compact;
    logic [12:0] usable_free;
    logic [6:0]  live_slot_count;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_CMP_INIT,
    S_CMP_RD,
    S_CMP_CHK,
    S_CMP_MOVE,
    S_CMP_END,
    S_PLACE,
    S_FREE_RD,
    S_FREE_CHK,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_DONE
  } seq_state_t;

endpackage

// ----- sv/slotted_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// slotted page allocator: sequencer, slot tables and page counters
// depends on spa_pkg
//
// channel   ports                      direction  handshake
// request   start, busy, in_req        in         taken when start && !busy
// result    out_strobe, out_res        out        one cycle strobe, no stall
//
// init, unknown and out-of-range free requests go straight to the result strobe
// a free reads its slot; a live slot is emptied, then empty slots are trimmed
// allocate: refused at once for a zero size, else an empty slot search when the page
// holds empty slots, a decision, compaction when the contiguous free space is too small,
// and placement; compaction scans all slots once per live object moved and once to end,
// one table read per compare through the single registered read port of the slot tables
// reset (synchronous, rst_n low) empties the page; table contents stay as they are
// results cannot be stalled: out_strobe is high for one cycle per request
module slotted_page_allocator_unit #(
  parameter int PAGE_BYTES = spa_pkg::PAGE_BYTES_DEF,
  parameter int MAX_SLOTS  = spa_pkg::MAX_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spa_pkg::in_t  in_req,
  output logic          out_strobe,
  output spa_pkg::out_t out_res
);
  import spa_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int FW    = OFF_W + 1;

  logic [OFF_W-1:0] off_mem [MAX_SLOTS];
  logic [OFF_W-1:0] size_mem [MAX_SLOTS];
  logic [OFF_W-1:0] off_q_r, size_q_r;

  seq_state_t       state_r, state_nxt;
  in_t              req_r;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] hole_r, hole_nxt;
  logic [OFF_W-1:0] fp_r, fp_nxt;
  logic [OFF_W-1:0] frag_r, frag_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             reuse_r, reuse_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic             compact_r, compact_nxt;
  logic [OFF_W-1:0] dest_r, dest_nxt;
  logic [OFF_W-1:0] bound_r, bound_nxt;
  logic             first_r, first_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [OFF_W-1:0] best_off_r, best_off_nxt;
  logic [OFF_W-1:0] best_size_r, best_size_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_t             out_r, out_nxt;

  logic             wr_off_en, wr_size_en;
  logic [IDX_W-1:0] wr_idx;
  logic [OFF_W-1:0] wr_off, wr_size;

  logic [FW-1:0]    front, unfrag, total_free, usable, need;
  logic             last_idx;

  // page arithmetic on the current counters
  always_comb begin
    front      = FW'(HDR_BYTES) + (FW'(total_r) << 3);
    unfrag     = ({1'b0, fp_r} > front) ? ({1'b0, fp_r} - front) : '0;
    total_free = unfrag + {1'b0, frag_r};
    if (hole_r != '0) begin
      usable = total_free;
    end else begin
      usable = (total_free > FW'(SLOT_BYTES)) ? (total_free - FW'(SLOT_BYTES)) : '0;
    end
    need     = {1'b0, req_r.obj_bytes} + (reuse_r ? '0 : FW'(SLOT_BYTES));
    last_idx = (CNT_W'(idx_r) == (total_r - CNT_W'(1))) || (total_r == '0);
  end

  always_ff @(posedge clk) begin
    if (wr_off_en) begin
      off_mem[wr_idx] <= wr_off;
    end
    if (wr_size_en) begin
      size_mem[wr_idx] <= wr_size;
    end
    off_q_r  <= off_mem[idx_r];
    size_q_r <= size_mem[idx_r];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (start) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (req_r.req_type)
          REQ_ALLOC: begin
            if (req_r.obj_bytes == '0) begin
              state_nxt = S_DONE;
            end else if (hole_r != '0) begin
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_DECIDE;
            end
          end
          REQ_FREE: begin
            if (32'(req_r.rel_slot) < 32'(total_r)) begin
              state_nxt = S_FREE_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (off_q_r == '0 || last_idx) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (!reuse_r && 32'(total_r) >= MAX_SLOTS) begin
          state_nxt = S_DONE;
        end else if ({1'b0, req_r.obj_bytes} > usable) begin
          state_nxt = S_DONE;
        end else if (need > unfrag) begin
          state_nxt = S_CMP_INIT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_CMP_INIT: state_nxt = (total_r == '0) ? S_CMP_END : S_CMP_RD;
      S_CMP_RD:   state_nxt = S_CMP_CHK;
      S_CMP_CHK:  state_nxt = last_idx ? S_CMP_MOVE : S_CMP_RD;
      S_CMP_MOVE: state_nxt = found_r ? S_CMP_RD : S_CMP_END;
      S_CMP_END:  state_nxt = S_PLACE;
      S_PLACE:    state_nxt = S_DONE;
      S_FREE_RD:  state_nxt = S_FREE_CHK;
      S_FREE_CHK: state_nxt = (off_q_r == '0) ? S_DONE : S_TRIM_RD;
      S_TRIM_RD:  state_nxt = S_TRIM_CHK;
      S_TRIM_CHK: begin
        if (off_q_r == '0 && total_r > CNT_W'(1)) begin
          state_nxt = S_TRIM_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and table writes
  always_comb begin
    total_nxt      = total_r;
    hole_nxt       = hole_r;
    fp_nxt         = fp_r;
    frag_nxt       = frag_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    reuse_nxt      = reuse_r;
    status_nxt     = status_r;
    offset_nxt     = offset_r;
    compact_nxt    = compact_r;
    dest_nxt       = dest_r;
    bound_nxt      = bound_r;
    first_nxt      = first_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_off_nxt   = best_off_r;
    best_size_nxt  = best_size_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    wr_off_en      = 1'b0;
    wr_size_en     = 1'b0;
    wr_idx         = idx_r;
    wr_off         = '0;
    wr_size        = req_r.obj_bytes;

    case (state_r)
      S_DISPATCH: begin
        status_nxt  = ST_OK;
        offset_nxt  = '0;
        slot_nxt    = '0;
        compact_nxt = 1'b0;
        reuse_nxt   = 1'b0;
        idx_nxt     = '0;
        case (req_r.req_type)
          REQ_INIT: begin
            total_nxt = '0;
            hole_nxt  = '0;
            fp_nxt    = OFF_W'(PAGE_BYTES);
            frag_nxt  = '0;
          end
          REQ_ALLOC: begin
            if (req_r.obj_bytes == '0) status_nxt = ST_ZERO_SIZE;
          end
          REQ_FREE: begin
            if (32'(req_r.rel_slot) < 32'(total_r)) begin
              idx_nxt = IDX_W'(req_r.rel_slot);
            end else begin
              status_nxt = ST_BAD_SLOT;
            end
          end
          default: status_nxt = ST_BAD_SLOT;
        endcase
      end
      S_SCAN_CHK: begin
        if (off_q_r == '0) begin
          reuse_nxt = 1'b1;
          slot_nxt  = idx_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DECIDE: begin
        if (!reuse_r && 32'(total_r) >= MAX_SLOTS) begin
          status_nxt = ST_TABLE_FULL;
        end else if ({1'b0, req_r.obj_bytes} > usable) begin
          status_nxt = ST_NO_SPACE;
        end
      end
      S_CMP_INIT: begin
        dest_nxt  = OFF_W'(PAGE_BYTES);
        first_nxt = 1'b1;
        found_nxt = 1'b0;
        idx_nxt   = '0;
      end
      // pick the highest live offset below the previous pick
      S_CMP_CHK: begin
        if (off_q_r != '0 && (first_r || off_q_r < bound_r) &&
            (!found_r || off_q_r > best_off_r)) begin
          found_nxt     = 1'b1;
          best_nxt      = idx_r;
          best_off_nxt  = off_q_r;
          best_size_nxt = size_q_r;
        end
        if (!last_idx) idx_nxt = idx_r + 1'b1;
      end
      S_CMP_MOVE: begin
        if (found_r) begin
          dest_nxt  = (best_size_r < dest_r) ? (dest_r - best_size_r) : '0;
          wr_off_en = 1'b1;
          wr_idx    = best_r;
          wr_off    = dest_nxt;
          bound_nxt = best_off_r;
          first_nxt = 1'b0;
          found_nxt = 1'b0;
          idx_nxt   = '0;
        end
      end
      S_CMP_END: begin
        frag_nxt    = '0;
        fp_nxt      = dest_r;
        compact_nxt = 1'b1;
      end
      S_PLACE: begin
        if (reuse_r) begin
          hole_nxt = hole_r - 1'b1;
        end else begin
          slot_nxt  = IDX_W'(total_r);
          total_nxt = total_r + 1'b1;
        end
        fp_nxt     = (req_r.obj_bytes < fp_r) ? (fp_r - req_r.obj_bytes) : '0;
        wr_off_en  = 1'b1;
        wr_size_en = 1'b1;
        wr_idx     = reuse_r ? slot_r : IDX_W'(total_r);
        wr_off     = fp_nxt;
        offset_nxt = fp_nxt;
      end
      S_FREE_CHK: begin
        if (off_q_r == '0) begin
          status_nxt = ST_BAD_SLOT;
        end else begin
          if (off_q_r == fp_r) begin
            fp_nxt = fp_r + size_q_r;
          end else begin
            frag_nxt = frag_r + size_q_r;
          end
          wr_off_en = 1'b1;
          wr_idx    = idx_r;
          hole_nxt  = hole_r + 1'b1;
          idx_nxt   = IDX_W'(total_r - 1'b1);
        end
      end
      // drop empty slots from the end of the array
      S_TRIM_CHK: begin
        if (off_q_r == '0) begin
          total_nxt = total_r - 1'b1;
          hole_nxt  = hole_r - 1'b1;
          idx_nxt   = idx_r - 1'b1;
        end
      end
      S_DONE: begin
        out_strobe_nxt          = 1'b1;
        out_nxt.status          = status_r;
        out_nxt.granted_slot    = (status_r == ST_OK && req_r.req_type == REQ_ALLOC) ?
                                  6'(slot_r) : '0;
        out_nxt.object_offset   = offset_r;
        out_nxt.did_compact     = compact_r;
        out_nxt.usable_free     = usable[OFF_W-1:0];
        out_nxt.live_slot_count = 7'(total_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      hole_r       <= '0;
      fp_r         <= OFF_W'(PAGE_BYTES);
      frag_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      hole_r       <= hole_nxt;
      fp_r         <= fp_nxt;
      frag_r       <= frag_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_req;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    reuse_r     <= reuse_nxt;
    status_r    <= status_nxt;
    offset_r    <= offset_nxt;
    compact_r   <= compact_nxt;
    dest_r      <= dest_nxt;
    bound_r     <= bound_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_off_r  <= best_off_nxt;
    best_size_r <= best_size_nxt;
    out_r       <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request taken but block not busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");
  a_holes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hole_r <= total_r) else $error("empty slot count above slot total");
  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= MAX_SLOTS) else $error("slot total above table depth");

endmodule
